[hw/rtl/rom2int_pkg.sv]
// Shared widths, constants, types and arithmetic helpers for the Roman numeral converter.
`default_nettype none

package rom2int_pkg;

   localparam int unsigned SYM_W       = 8;
   localparam int unsigned VAL_W       = 16;
   localparam int unsigned GRP_W       = 15;
   localparam int unsigned LV_W        = 10;
   localparam int unsigned CNT_W       = 6;
   localparam int unsigned MAX_LEN_DEF = 32;

   localparam logic [SYM_W-1:0] CH_I = 8'h49;
   localparam logic [SYM_W-1:0] CH_V = 8'h56;
   localparam logic [SYM_W-1:0] CH_X = 8'h58;
   localparam logic [SYM_W-1:0] CH_L = 8'h4C;
   localparam logic [SYM_W-1:0] CH_C = 8'h43;
   localparam logic [SYM_W-1:0] CH_D = 8'h44;
   localparam logic [SYM_W-1:0] CH_M = 8'h4D;

   localparam logic signed [VAL_W:0] VAL_CAP_WIDE = 17'sd32000;
   localparam logic signed [VAL_W-1:0] VAL_CAP    = 16'sd32000;
   localparam logic [GRP_W-1:0] GRP_CAP           = 15'd32000;

   // Everything the finishing stage needs to close the last group of a numeral.
   typedef struct packed {
      logic signed [VAL_W-1:0] total;
      logic [GRP_W-1:0]        pend;
      logic                    pend_valid;
      logic [GRP_W-1:0]        run_sum;
      logic                    bad_letter;
      logic                    too_long;
   } rom2int_fin_type;

   function automatic logic [LV_W-1:0] letter_value(input logic [SYM_W-1:0] sym);
      logic [LV_W-1:0] v;
      case (sym)
         CH_I:    v = 10'd1;
         CH_V:    v = 10'd5;
         CH_X:    v = 10'd10;
         CH_L:    v = 10'd50;
         CH_C:    v = 10'd100;
         CH_D:    v = 10'd500;
         CH_M:    v = 10'd1000;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Extends an open run by one more copy of its letter, saturating at the cap.
   function automatic logic [GRP_W-1:0] run_add(input logic [GRP_W-1:0] run_sum,
                                                input logic [LV_W-1:0]  v);
      logic [GRP_W:0] s;
      s = {1'b0, run_sum} + (GRP_W+1)'(v);
      if (s > {1'b0, GRP_CAP}) begin
         return GRP_CAP;
      end
      return s[GRP_W-1:0];
   endfunction

   // Adds or subtracts one group from the total, saturating to the symmetric cap.
   function automatic logic signed [VAL_W-1:0] group_acc(input logic signed [VAL_W-1:0] total,
                                                         input logic [GRP_W-1:0]        grp,
                                                         input logic                    sub);
      logic signed [VAL_W:0] t;
      logic signed [VAL_W:0] g;
      logic signed [VAL_W:0] s;
      t = {total[VAL_W-1], total};
      g = $signed({2'b00, grp});
      s = sub ? (t - g) : (t + g);
      if (s > VAL_CAP_WIDE) begin
         return VAL_CAP;
      end
      if (s < -VAL_CAP_WIDE) begin
         return -VAL_CAP;
      end
      return s[VAL_W-1:0];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/rom2int_if.sv]
// Valid/ready channel interfaces for the character stream and the result stream.
`default_nettype none

interface rom2int_req_if;
   import rom2int_pkg::*;
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface rom2int_rsp_if;
   import rom2int_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] value;
   logic                    bad_letter;
   logic                    too_long;

   modport source (output valid, output value, output bad_letter, output too_long, input ready);
   modport sink   (input valid, input value, input bad_letter, input too_long, output ready);
endinterface

`default_nettype wire

[hw/rtl/rom2int_scan.sv]
// Input register and per-character scan of runs and groups.
`default_nettype none

module rom2int_scan #(
   parameter int unsigned MAX_LEN = rom2int_pkg::MAX_LEN_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   rom2int_req_if.sink                  req_chan,
   output logic                         fin_valid,
   input  logic                         fin_ready,
   output rom2int_pkg::rom2int_fin_type fin_data
);
   import rom2int_pkg::*;

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

   logic                    in_vld_ff;
   logic [SYM_W-1:0]        in_sym_ff;
   logic                    in_last_ff;

   logic [SYM_W-1:0]        run_letter_ff;
   logic [GRP_W-1:0]        run_sum_ff;
   logic [GRP_W-1:0]        pend_ff;
   logic                    pend_vld_ff;
   logic signed [VAL_W-1:0] total_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    bad_ff;
   logic                    long_ff;

   logic [LV_W-1:0]         v;
   logic                    first;
   logic                    same;
   logic                    close_mid;
   logic                    at_max;
   logic                    in_go;
   logic signed [VAL_W-1:0] total_in;
   logic [GRP_W-1:0]        pend_in;
   logic                    pend_vld_in;
   logic [GRP_W-1:0]        run_sum_in;
   logic [CNT_W-1:0]        cnt_in;
   logic                    bad_in;
   logic                    long_in;

   always_comb begin
      v         = letter_value(in_sym_ff);
      first     = (cnt_ff == '0);
      same      = !first && (in_sym_ff == run_letter_ff);
      close_mid = !first && !same;
      at_max    = (cnt_ff >= CNT_MAX);

      // A change of letter closes the open run; the group before it is now resolved.
      if (close_mid && pend_vld_ff) begin
         total_in = group_acc(total_ff, pend_ff, pend_ff < run_sum_ff);
      end else begin
         total_in = total_ff;
      end
      pend_in     = close_mid ? run_sum_ff : pend_ff;
      pend_vld_in = pend_vld_ff | close_mid;
      run_sum_in  = same ? run_add(run_sum_ff, v) : GRP_W'(v);
      cnt_in      = at_max ? cnt_ff : cnt_ff + 1'b1;
      bad_in      = bad_ff | (v == '0);
      long_in     = long_ff | at_max;

      in_go          = in_vld_ff && (!in_last_ff || fin_ready);
      req_chan.ready = !in_vld_ff || in_go;
      fin_valid      = in_vld_ff && in_last_ff;
      fin_data       = '{total: total_in, pend: pend_in, pend_valid: pend_vld_in,
                         run_sum: run_sum_in, bad_letter: bad_in, too_long: long_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         run_letter_ff <= '0;
         run_sum_ff    <= '0;
         pend_ff       <= '0;
         pend_vld_ff   <= 1'b0;
         total_ff      <= '0;
         cnt_ff        <= '0;
         bad_ff        <= 1'b0;
         long_ff       <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_vld_ff <= req_chan.valid;
         end
         if (in_go) begin
            if (in_last_ff) begin
               run_letter_ff <= '0;
               run_sum_ff    <= '0;
               pend_ff       <= '0;
               pend_vld_ff   <= 1'b0;
               total_ff      <= '0;
               cnt_ff        <= '0;
               bad_ff        <= 1'b0;
               long_ff       <= 1'b0;
            end else begin
               run_letter_ff <= in_sym_ff;
               run_sum_ff    <= run_sum_in;
               pend_ff       <= pend_in;
               pend_vld_ff   <= pend_vld_in;
               total_ff      <= total_in;
               cnt_ff        <= cnt_in;
               bad_ff        <= bad_in;
               long_ff       <= long_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_sym_ff  <= req_chan.symbol;
         in_last_ff <= req_chan.last;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/rom2int_final.sv]
// Closes the last group of a numeral and holds the result word for the receiver.
`default_nettype none

module rom2int_final (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fin_valid,
   output logic                         fin_ready,
   input  rom2int_pkg::rom2int_fin_type fin_data,
   rom2int_rsp_if.source                rsp_chan
);
   import rom2int_pkg::*;

   logic                    fin_vld_ff;
   rom2int_fin_type         fin_ff;
   logic                    out_vld_ff;
   logic signed [VAL_W-1:0] value_ff;
   logic                    bad_ff;
   logic                    long_ff;

   logic                    out_rdy;
   logic signed [VAL_W-1:0] t_close;
   logic signed [VAL_W-1:0] value_in;

   always_comb begin
      out_rdy   = !out_vld_ff || rsp_chan.ready;
      fin_ready = !fin_vld_ff || out_rdy;

      if (fin_ff.pend_valid) begin
         t_close = group_acc(fin_ff.total, fin_ff.pend, fin_ff.pend < fin_ff.run_sum);
      end else begin
         t_close = fin_ff.total;
      end
      // The rightmost group is always added; an over-long numeral reports zero.
      value_in = fin_ff.too_long ? '0 : group_acc(t_close, fin_ff.run_sum, 1'b0);

      rsp_chan.valid      = out_vld_ff;
      rsp_chan.value      = value_ff;
      rsp_chan.bad_letter = bad_ff;
      rsp_chan.too_long   = long_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (fin_ready) begin
            fin_vld_ff <= fin_valid;
         end
         if (out_rdy) begin
            out_vld_ff <= fin_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid && fin_ready) begin
         fin_ff <= fin_data;
      end
      if (out_rdy && fin_vld_ff) begin
         value_ff <= value_in;
         bad_ff   <= fin_ff.bad_letter;
         long_ff  <= fin_ff.too_long;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/roman_numeral_to_integer.sv]
// Top level of the Roman numeral to integer converter.
//
// Characters arrive on req_chan, one ASCII letter per word, with last set on
// the final letter of a numeral. One result word per numeral leaves on rsp_chan:
// the signed value, a flag for any character that is not I V X L C D M, and a
// flag for a numeral longer than MAX_LEN characters, in which case the value is 0.
// Runs of one letter form a group; a group smaller than the one to its right
// is subtracted, otherwise it is added. Sums saturate at plus or minus 32000.
//
// Throughput is one character word per cycle, with no gap between numerals,
// as long as the finishing stage can take each last character. A numeral's
// result passes the input register, the finishing register and the result
// register. The scan stage does one table lookup and one group resolution
// per cycle; the finishing stage closes the final two groups.
//
// Synchronous reset empties every stage and clears the running state. When
// the receiver holds rsp_chan.ready low the result word is held steady; the
// finishing stage and the input register still take words, and req_chan.ready
// falls only when a further last character would have nowhere to go.
`default_nettype none

module roman_numeral_to_integer #(
   parameter int unsigned MAX_LEN = rom2int_pkg::MAX_LEN_DEF
) (
   input  logic          clock,
   input  logic          reset,
   rom2int_req_if.sink   req_chan,
   rom2int_rsp_if.source rsp_chan
);
   import rom2int_pkg::*;

   logic            fin_valid;
   logic            fin_ready;
   rom2int_fin_type fin_data;

   rom2int_scan #(
      .MAX_LEN (MAX_LEN)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .fin_valid (fin_valid),
      .fin_ready (fin_ready),
      .fin_data  (fin_data)
   );

   rom2int_final u_final (
      .clock     (clock),
      .reset     (reset),
      .fin_valid (fin_valid),
      .fin_ready (fin_ready),
      .fin_data  (fin_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

[hw/rtl/rom2int_chk.sv]
// Port-level checks on the converter, attached to the top level by bind.
`default_nettype none

module rom2int_chk (
   input logic           clock,
   input logic           reset,
   rom2int_rsp_if.source rsp_chan
);
   import rom2int_pkg::*;

   // A result word waiting for the receiver stays offered.
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid)
      else $error("result word withdrawn while stalled");

   // A stalled result word keeps its value.
   a_value_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> $stable(rsp_chan.value))
      else $error("result value changed while stalled");

   // Reset leaves no result word on the output.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result word present after reset");

   // An over-long numeral reports a zero value.
   a_long_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.too_long |-> rsp_chan.value == '0)
      else $error("over-long numeral with non-zero value");

   // Saturation keeps every reported value within the cap.
   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.value <= VAL_CAP) && (rsp_chan.value >= -VAL_CAP))
      else $error("result value outside the saturation range");

endmodule

bind roman_numeral_to_integer rom2int_chk u_chk (
   .clock    (clock),
   .reset    (reset),
   .rsp_chan (rsp_chan)
);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the Roman numeral to integer converter.
`timescale 1ns / 100ps

module tb;
   import rom2int_pkg::*;

   // Run control. The cycle limit allows every character its longest gap,
   // every result its longest stall and the long hold-off, many times over.
   localparam int MAX_CHARS    = MAX_LEN_DEF;
   localparam int SAT_LIMIT    = 32000;
   localparam int RANDOM_CHARS = 1700;
   localparam int HOLD_CYCLES  = 250;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 400000;

   // One result word as the converter should present it.
   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    bad_letter;
      logic                    too_long;
   } numeral_result_type;

   // One row of the directed table: a numeral and, where it is obvious, its result.
   typedef struct {
      string              text;
      bit                 typed;
      numeral_result_type result;
   } directed_row_type;

   logic clock;
   logic reset;

   rom2int_req_if req_chan ();
   rom2int_rsp_if rsp_chan ();

   roman_numeral_to_integer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Results that the converter still owes, oldest first.
   numeral_result_type expected_results[$];
   directed_row_type   directed_rows[$];
   // Characters of the numeral that the sender is about to present.
   logic [SYM_W-1:0] numeral_chars[$];

   // Scoreboard and summary counters.
   int mismatches    = 0;
   int chars_sent    = 0;
   int numerals_sent = 0;
   int results_seen  = 0;
   int bad_seen_cnt  = 0;
   int long_seen_cnt = 0;
   int cycle_count   = 0;

   // Handshake shaping. no_gaps makes the sender present words back to back;
   // hold_rsp asks the receiver for one long hold-off.
   bit no_gaps  = 0;
   bit hold_rsp = 0;

   // Decoder state of the predictor, at the widths that the block keeps.
   logic [SYM_W-1:0]        open_letter;
   logic [GRP_W-1:0]        open_sum;
   logic [GRP_W-1:0]        held_group;
   logic                    held_valid;
   logic signed [VAL_W-1:0] running_total;
   logic [CNT_W-1:0]        seen_count;
   logic                    saw_bad;
   logic                    saw_long;

   logic [SYM_W-1:0] roman_letters [7] = '{CH_I, CH_V, CH_X, CH_L, CH_C, CH_D, CH_M};

   // Clock: 12 ns period.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The cycle counter ends a run that has hung.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d results still outstanding", cycle_count,
               expected_results.size());
      $display("Mismatches found");
      $finish;
   end

   // Saturates a sum to the symmetric range that the converter keeps.
   function automatic int sat(input int x);
      if (x > SAT_LIMIT) begin
         return SAT_LIMIT;
      end
      if (x < -SAT_LIMIT) begin
         return -SAT_LIMIT;
      end
      return x;
   endfunction

   task automatic clear_decoder();
      open_letter   = '0;
      open_sum      = '0;
      held_group    = '0;
      held_valid    = 1'b0;
      running_total = '0;
      seen_count    = '0;
      saw_bad       = 1'b0;
      saw_long      = 1'b0;
   endtask

   // Closes a group. The group held before it is now known to stand left of
   // this one, so it is subtracted when smaller and added otherwise.
   task automatic fold_group(input int g);
      int h;
      h = int'(held_group);
      if (held_valid) begin
         running_total = VAL_W'(sat(int'(running_total) + ((h < g) ? -h : h)));
      end
      held_group = GRP_W'(g);
      held_valid = 1'b1;
   endtask

   // Advances the predictor by one accepted character word. On the last
   // character of a numeral it hands back the result and returns to reset.
   task automatic predict_char(input logic [SYM_W-1:0] sym, input logic lst,
                               output bit produced, output numeral_result_type res);
      int v;
      bit first;
      case (sym)
         CH_I:    v = 1;
         CH_V:    v = 5;
         CH_X:    v = 10;
         CH_L:    v = 50;
         CH_C:    v = 100;
         CH_D:    v = 500;
         CH_M:    v = 1000;
         default: v = 0;
      endcase
      first    = (seen_count == 0);
      produced = 1'b0;
      res      = '0;

      // An unknown character counts as nothing but marks the numeral.
      if (v == 0) begin
         saw_bad = 1'b1;
      end
      // The count stops at the length limit; any further character marks it too long.
      if (int'(seen_count) >= MAX_CHARS) begin
         saw_long = 1'b1;
      end else begin
         seen_count = seen_count + 1'b1;
      end

      // Runs are formed by character code, unknown codes included.
      if (first) begin
         open_letter = sym;
         open_sum    = GRP_W'(v);
      end else if (sym == open_letter) begin
         open_sum = GRP_W'(sat(int'(open_sum) + v));
      end else begin
         fold_group(int'(open_sum));
         open_letter = sym;
         open_sum    = GRP_W'(v);
      end

      if (lst) begin
         // The open run becomes the rightmost group, which is always added.
         fold_group(int'(open_sum));
         running_total  = VAL_W'(sat(int'(running_total) + int'(held_group)));
         res.value      = saw_long ? '0 : running_total;
         res.bad_letter = saw_bad;
         res.too_long   = saw_long;
         produced       = 1'b1;
         clear_decoder();
      end
   endtask

   // Presents the characters in numeral_chars, one word each, with last on the
   // final one. Each word waits a random gap first unless no_gaps is set. A
   // typed expectation replaces the predicted one, though the predictor still
   // runs so that its state follows the block.
   task automatic send_numeral(input bit typed, input numeral_result_type typed_res);
      int                 gap;
      bit                 produced;
      numeral_result_type res;
      for (int i = 0; i < numeral_chars.size(); i++) begin
         gap = no_gaps ? 0 : $urandom_range(0, 15);
         if (gap > 0) begin
            req_chan.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_chan.valid  = 1'b1;
         req_chan.symbol = numeral_chars[i];
         req_chan.last   = (i == numeral_chars.size() - 1);
         do @(posedge clock); while (!req_chan.ready);
         predict_char(numeral_chars[i], (i == numeral_chars.size() - 1), produced, res);
         if (produced) begin
            if (typed) begin
               res = typed_res;
            end
            expected_results = {expected_results, res};
         end
         chars_sent++;
         @(negedge clock);
      end
      numerals_sent++;
   endtask

   task automatic add_row(input string text, input bit typed, input int value,
                          input bit bad, input bit long_flag);
      directed_row_type row;
      row.text              = text;
      row.typed             = typed;
      row.result.value      = VAL_W'(value);
      row.result.bad_letter = bad;
      row.result.too_long   = long_flag;
      directed_rows         = {directed_rows, row};
   endtask

   // Receiver: holds ready low for a random number of cycles before each
   // word, with stretches of no stalling, and once for a long hold-off so
   // that the converter fills up and stalls its input.
   initial begin : drive_ready
      int wait_cycles;
      bit rsp_fast;
      rsp_fast       = 1'b0;
      rsp_chan.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp       = 1'b0;
            rsp_chan.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if ($urandom_range(0, 19) == 0) begin
            rsp_fast = !rsp_fast;
         end
         wait_cycles = rsp_fast ? 0 : $urandom_range(0, 15);
         if (wait_cycles > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   // Checker: every accepted result word is compared with the oldest expectation.
   always @(posedge clock) begin : check_results
      numeral_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (rsp_chan.bad_letter) begin
            bad_seen_cnt++;
         end
         if (rsp_chan.too_long) begin
            long_seen_cnt++;
         end
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result word, value %0d bad_letter %0b too_long %0b",
                     $time, rsp_chan.value, rsp_chan.bad_letter, rsp_chan.too_long);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_chan.value !== want.value) begin
               $display("%0t: value expected %0d, got %0d", $time, want.value,
                        rsp_chan.value);
               mismatches++;
            end
            if (rsp_chan.bad_letter !== want.bad_letter) begin
               $display("%0t: bad_letter expected %0b, got %0b", $time, want.bad_letter,
                        rsp_chan.bad_letter);
               mismatches++;
            end
            if (rsp_chan.too_long !== want.too_long) begin
               $display("%0t: too_long expected %0b, got %0b", $time, want.too_long,
                        rsp_chan.too_long);
               mismatches++;
            end
         end
      end
   end

   // Main sequence: reset, the directed table, the random numerals, the drain.
   initial begin : stimulus
      string              text;
      int                 kind;
      int                 len;
      int                 numeral_idx;
      int                 pos;
      bit                 noise;
      logic [SYM_W-1:0]   cur;
      numeral_result_type none;

      none            = '0;
      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.symbol = '0;
      req_chan.last   = 1'b0;
      clear_decoder();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table. Single letters, the unknown characters and the length
      // extremes have results that can be typed in; the rest go to the predictor.
      add_row("I", 1, 1, 0, 0);
      add_row("V", 1, 5, 0, 0);
      add_row("X", 1, 10, 0, 0);
      add_row("L", 1, 50, 0, 0);
      add_row("C", 1, 100, 0, 0);
      add_row("D", 1, 500, 0, 0);
      add_row("M", 1, 1000, 0, 0);
      add_row("IV", 0, 0, 0, 0);
      add_row("IX", 0, 0, 0, 0);
      add_row("XL", 0, 0, 0, 0);
      add_row("CM", 0, 0, 0, 0);
      add_row("MCMXCIV", 0, 0, 0, 0);
      add_row("IIV", 0, 0, 0, 0);
      // Two subtracted groups in a row give a negative total.
      add_row("VIIIIIIX", 0, 0, 0, 0);
      add_row("?", 1, 0, 1, 0);
      add_row("i", 1, 0, 1, 0);
      add_row("\377", 1, 0, 1, 0);
      add_row("XQX", 0, 0, 0, 0);
      text = "";
      repeat (MAX_CHARS) text = {text, "M"};
      // The longest legal numeral reaches the saturation value exactly.
      add_row(text, 1, 32000, 0, 0);
      text = {text, "M"};
      // One character over the limit: flagged, and the value is forced to zero.
      add_row(text, 1, 0, 0, 1);

      foreach (directed_rows[r]) begin
         numeral_chars.delete();
         for (int i = 0; i < directed_rows[r].text.len(); i++) begin
            cur           = directed_rows[r].text[i];
            numeral_chars = {numeral_chars, cur};
         end
         no_gaps = ($urandom_range(0, 3) == 0);
         send_numeral(directed_rows[r].typed, directed_rows[r].result);
      end

      // Random numerals: mostly runs of real letters, with some unknown
      // characters mixed in, pure noise, over-long strings and lengths at the limit.
      numeral_idx = 0;
      while (chars_sent < RANDOM_CHARS + 80) begin
         kind  = $urandom_range(0, 99);
         noise = 1'b0;
         if (kind < 78) begin
            len = $urandom_range(1, 10);
         end else if (kind < 85) begin
            len   = $urandom_range(1, 6);
            noise = 1'b1;
         end else if (kind < 90) begin
            len = $urandom_range(MAX_CHARS + 1, MAX_CHARS + 8);
         end else if (kind < 95) begin
            len = $urandom_range(MAX_CHARS - 1, MAX_CHARS);
         end else begin
            len   = 1;
            noise = 1'b1;
         end

         numeral_chars.delete();
         cur = roman_letters[$urandom_range(0, 6)];
         for (int i = 0; i < len; i++) begin
            if (noise) begin
               cur = SYM_W'($urandom_range(0, 255));
            end else if (i > 0 && $urandom_range(0, 2) != 0) begin
               cur = roman_letters[$urandom_range(0, 6)];
            end
            numeral_chars = {numeral_chars, cur};
         end
         // At the length limit, now and then a string of the largest letter alone.
         if (kind >= 90 && kind < 95 && $urandom_range(0, 2) == 0) begin
            foreach (numeral_chars[i]) numeral_chars[i] = CH_M;
         end
         if (kind >= 70 && kind < 78) begin
            pos                = $urandom_range(0, len - 1);
            numeral_chars[pos] = SYM_W'($urandom_range(0, 255));
         end

         // A window of back-to-back words while the receiver holds off.
         if (numeral_idx == 40) begin
            hold_rsp = 1'b1;
         end
         if (numeral_idx >= 40 && numeral_idx < 70) begin
            no_gaps = 1'b1;
         end else begin
            no_gaps = ($urandom_range(0, 4) == 0);
         end
         // Once, the sender waits for every owed result before going on.
         if (numeral_idx == 120) begin
            req_chan.valid = 1'b0;
            wait (expected_results.size() == 0);
            @(negedge clock);
         end

         send_numeral(1'b0, none);
         numeral_idx++;
      end

      req_chan.valid = 1'b0;
      req_chan.last  = 1'b0;
      wait (expected_results.size() == 0);
      // The drain wait catches any stray word behind the last one.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d numerals in %0d character words; checked %0d result words.",
               numerals_sent, chars_sent, results_seen);
      $display("Of those, %0d carried an unknown character and %0d were too long.",
               bad_seen_cnt, long_seen_cnt);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[roman_numeral_to_integer.f]
hw/rtl/rom2int_pkg.sv
hw/rtl/rom2int_if.sv
hw/rtl/rom2int_scan.sv
hw/rtl/rom2int_final.sv
hw/rtl/roman_numeral_to_integer.sv
hw/rtl/rom2int_chk.sv
tb/tb.sv
